// File: rtl/sha256_stream_hasher_macros.svh
// Assertion macros used by the checker file.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// Implication checked every clock outside reset.
`define SHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int QUEUE_DEPTH = 4;

   typedef logic [31:0] word_type;

   // One classified byte passed from front to back.
   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       last;
   } entry_type;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int         LEN_POS  = 56;

   function automatic word_type rotr(word_type x, int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Accepts request transfers and pushes those with a byte or last into a small queue.
// ----------------------------------------------------------------------------
module shs_front #(
   parameter int DEPTH = shs_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_valid,
   input  logic                req_last,
   output logic                pop_valid,
   input  logic                pop,
   output shs_pkg::entry_type  pop_entry
);
   localparam int AW = $clog2(DEPTH);

   shs_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          push, take;

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   // Empty non-final items do nothing; drop them here.
   assign push      = req_valid && !req_stall && (req_byte_valid || req_last);
   assign pop_valid = (cnt_ff != '0);
   assign take      = pop && pop_valid;
   assign pop_entry = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{data: req_data_byte, byte_valid: req_byte_valid,
                            last: req_last};
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (take) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(take);
      end
   end
endmodule

// File: rtl/shs_back.sv
// ----------------------------------------------------------------------------
// shs_back
// Buffers bytes, pads, runs the 64 rounds and streams the digest.
// ----------------------------------------------------------------------------
module shs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop,
   input  shs_pkg::entry_type  pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);
   typedef enum logic [2:0] {
      S_COLLECT, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
   } state_type;

   state_type        state_ff;
   shs_pkg::word_type blk_ff [16];   // block buffer, big-endian words
   logic [5:0]       fill_ff;
   logic [60:0]      count_ff;
   shs_pkg::word_type h_ff [8];
   shs_pkg::word_type v_ff [8];
   shs_pkg::word_type w_ff [16];
   logic [5:0]       round_ff;
   logic [3:0]       load_ff;
   logic             final_ff;   // padding pending after this compression
   logic             len_ff;     // this compression holds the length field
   logic             pad_lead_ff; // pending pad block starts with 0x80
   logic [2:0]       oidx_ff;
   logic             rvalid_ff;

   logic [63:0] bits;
   assign bits = {count_ff, 3'b000};

   // Round datapath.
   shs_pkg::word_type t1, t2, s0, s1, wnew, wcur, ld_word, put_word;
   shs_pkg::word_type pad_blk [16];
   logic              len_fits;
   always_comb begin
      s0   = shs_pkg::rotr(w_ff[1], 7) ^ shs_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = shs_pkg::rotr(w_ff[14], 17) ^ shs_pkg::rotr(w_ff[14], 19)
           ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      wcur = w_ff[0];
      t1   = v_ff[7] + (shs_pkg::rotr(v_ff[4], 6) ^ shs_pkg::rotr(v_ff[4], 11)
           ^ shs_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + shs_pkg::ROUND_K[round_ff] + wcur;
      t2   = (shs_pkg::rotr(v_ff[0], 2) ^ shs_pkg::rotr(v_ff[0], 13)
           ^ shs_pkg::rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      ld_word = blk_ff[load_ff];
      // Merge the incoming byte into its word.
      put_word = blk_ff[fill_ff[5:2]];
      case (fill_ff[1:0])
         2'd0:    put_word[31:24] = pop_entry.data;
         2'd1:    put_word[23:16] = pop_entry.data;
         2'd2:    put_word[15:8]  = pop_entry.data;
         default: put_word[7:0]   = pop_entry.data;
      endcase
      // Padded tail block: keep bytes below fill, then 0x80, zeros, length if it fits.
      len_fits = (fill_ff < 6'(shs_pkg::LEN_POS));
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (len_fits && (4*i + j) >= shs_pkg::LEN_POS)
               pad_blk[i][8*(3-j) +: 8] = bits[8*(63 - 4*i - j) +: 8];
            else if (6'(4*i + j) == fill_ff)
               pad_blk[i][8*(3-j) +: 8] = shs_pkg::PAD_BYTE;
            else if (6'(4*i + j) > fill_ff)
               pad_blk[i][8*(3-j) +: 8] = 8'h00;
            else
               pad_blk[i][8*(3-j) +: 8] = blk_ff[i][8*(3-j) +: 8];
         end
      end
   end

   assign pop             = (state_ff == S_COLLECT) && pop_valid;
   assign rsp_valid       = rvalid_ff;
   assign rsp_digest_word = h_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_COLLECT;
         fill_ff     <= '0;
         count_ff    <= '0;
         final_ff    <= 1'b0;
         len_ff      <= 1'b0;
         pad_lead_ff <= 1'b0;
         rvalid_ff   <= 1'b0;
         oidx_ff     <= '0;
         round_ff    <= '0;
         load_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= shs_pkg::INIT_HASH[i];
      end else begin
         case (state_ff)
            S_COLLECT: begin
               if (pop_valid) begin
                  final_ff <= pop_entry.last;
                  if (pop_entry.byte_valid) begin
                     blk_ff[fill_ff[5:2]] <= put_word;
                     count_ff <= count_ff + 61'd1;
                     fill_ff  <= fill_ff + 6'd1;
                     if (fill_ff == 6'd63) begin
                        // Full block; a last byte here leaves an empty tail.
                        pad_lead_ff <= pop_entry.last;
                        len_ff   <= 1'b0;
                        load_ff  <= '0;
                        state_ff <= S_LOAD;
                     end else if (pop_entry.last) begin
                        state_ff <= S_PAD;
                     end
                  end else begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // Write 0x80, zeros, and length if it fits.
               for (int i = 0; i < 16; i++) blk_ff[i] <= pad_blk[i];
               len_ff      <= len_fits;
               final_ff    <= !len_fits;
               pad_lead_ff <= 1'b0;
               fill_ff     <= '0;
               load_ff     <= '0;
               state_ff    <= S_LOAD;
            end
            S_LOAD: begin
               // Shift the 16 message words into the schedule window.
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= ld_word;
               load_ff  <= load_ff + 4'd1;
               if (load_ff == 4'd15) begin
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  round_ff <= '0;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (len_ff) begin
                  oidx_ff   <= '0;
                  rvalid_ff <= 1'b1;
                  state_ff  <= S_OUT;
               end else if (final_ff) begin
                  // Second pad block: 0x80 for an empty tail, zeros, length.
                  blk_ff[0] <= {(pad_lead_ff ? shs_pkg::PAD_BYTE : 8'h00), 24'h000000};
                  for (int i = 1; i < 14; i++) blk_ff[i] <= '0;
                  blk_ff[14]  <= bits[63:32];
                  blk_ff[15]  <= bits[31:0];
                  pad_lead_ff <= 1'b0;
                  final_ff    <= 1'b0;
                  len_ff      <= 1'b1;
                  load_ff     <= '0;
                  state_ff    <= S_LOAD;
               end else begin
                  state_ff <= S_COLLECT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     rvalid_ff <= 1'b0;
                     len_ff    <= 1'b0;
                     count_ff  <= '0;
                     fill_ff   <= '0;
                     for (int i = 0; i < 8; i++) h_ff[i] <= shs_pkg::INIT_HASH[i];
                     state_ff  <= S_COLLECT;
                  end
               end
            end
            default: state_ff <= S_COLLECT;
         endcase
      end
   end
endmodule

// File: rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with digest output as eight words.
// ----------------------------------------------------------------------------
// One byte arrives per request transfer; a request with last set closes the
// message and eight response transfers follow, word 0 first. A front queue
// of QUEUE_DEPTH entries takes bytes at one per cycle while not full; the back
// part stores one byte per cycle while collecting and, on every 64th byte,
// compresses the block (16 word loads, 64 rounds of the single round unit,
// one add), during which it takes no bytes and the queue fills and then stalls.
// Finishing takes a padding step where needed plus one or two compressions,
// then the eight digest words are streamed out, held by any response stalls.
module sha256_stream_hasher #(
   parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   logic               pop_valid, pop;
   shs_pkg::entry_type pop_entry;

   // Front: accept and drop no-op items, hold the rest in the queue.
   shs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte,
      .req_byte_valid, .req_last, .pop_valid, .pop, .pop_entry
   );

   // Back: buffer, pad, compress and stream the digest.
   shs_back u_back (
      .clock, .reset, .pop_valid, .pop, .pop_entry, .rsp_valid, .rsp_stall,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );
endmodule

// File: rtl/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks for the hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"
module shs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   `SHS_ASSERT_IMP(a_last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7))
   `SHS_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
   `SHS_ASSERT_NEXT(a_start_zero, clock, reset, !rsp_valid, !rsp_valid || rsp_word_index == 3'd0)
   `SHS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word_index))
endmodule

bind sha256_stream_hasher shs_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_word_index, .rsp_last_word
);
